[src/pktr_pkg.sv]
package pktr_pkg;

  localparam int unsigned NumLights = 4;

  localparam int unsigned IdW    = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 32;
  localparam int unsigned LightW = 3;
  localparam int unsigned IvalW  = 16;

  localparam int unsigned SlotW = (NumLights > 1) ? $clog2(NumLights) : 1;
  localparam int unsigned RankW = SlotW;
  localparam int unsigned LeftW = $clog2(NumLights + 1);

  localparam logic [IvalW-1:0]  IvalReset = IvalW'(48);
  localparam logic [TotalW-1:0] TotalMax  = {TotalW{1'b1}};

  typedef logic [TotalW-1:0] total_t;
  typedef logic [LightW-1:0] light_t;

  // One ranked report, best light first.
  typedef struct packed {
    light_t [NumLights-1:0] light;
    total_t [NumLights-1:0] total;
  } report_t;

endpackage

[src/pktr_in_if.sv]
interface pktr_in_if;
  import pktr_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdW-1:0]    light_id;
  logic [CountW-1:0] car_count;

  modport source(output valid, output light_id, output car_count, input ready);
  modport sink(input valid, input light_id, input car_count, output ready);
endinterface

[src/pktr_out_if.sv]
interface pktr_out_if;
  import pktr_pkg::*;

  logic              valid;
  logic              ready;
  logic [LightW-1:0] ranked_light;
  logic [TotalW-1:0] ranked_total;
  logic              last_of_report;

  modport source(output valid, output ranked_light, output ranked_total,
                 output last_of_report, input ready);
  modport sink(input valid, input ranked_light, input ranked_total,
               input last_of_report, output ready);
endinterface

[src/pktr_tally.sv]
module pktr_tally
  import pktr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IvalW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IdW-1:0]          light_id_i,
  input  logic [CountW-1:0]       car_count_i,
  input  logic                    buf_free_i,
  output logic                    report_load_o,
  output total_t [NumLights-1:0]  totals_o
);

  logic [IvalW-1:0]      ival_q;
  logic [IvalW-1:0]      since_q, since_d, since_inc;
  logic                  in_vld_q;
  logic [IdW-1:0]        id_q;
  logic [CountW-1:0]     cnt_q;
  logic                  fire_q, fire_d;
  total_t [NumLights-1:0] tot_q, tot_upd;
  logic                  accept, advance, id_ok;
  logic [SlotW-1:0]      slot;
  logic [TotalW:0]       sum;

  assign since_inc = since_q + IvalW'(1);
  assign fire_d    = (since_inc == ival_q);
  assign since_d   = fire_d ? '0 : since_inc;

  // A report beat needs the buffer; plain records always move on.
  assign advance    = in_vld_q && (!fire_q || buf_free_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign id_ok = (id_q != '0) && (id_q <= IdW'(NumLights));
  assign slot  = SlotW'(id_q - IdW'(1));
  assign sum   = {1'b0, tot_q[slot]} + {{(TotalW + 1 - CountW){1'b0}}, cnt_q};

  always_comb begin
    tot_upd = tot_q;
    if (id_ok) begin
      tot_upd[slot] = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
    end
  end

  assign totals_o      = tot_upd;
  assign report_load_o = advance && fire_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_q   <= IvalReset;
      since_q  <= '0;
      in_vld_q <= 1'b0;
      fire_q   <= 1'b0;
      tot_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        ival_q <= cfg_wdata_i;
      end
      if (accept) begin
        since_q <= since_d;
        fire_q  <= fire_d;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        tot_q <= tot_upd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q  <= light_id_i;
      cnt_q <= car_count_i;
    end
  end

endmodule

[src/pktr_rank.sv]
module pktr_rank
  import pktr_pkg::*;
(
  input  total_t [NumLights-1:0] totals_i,
  output report_t                report_o
);

  logic [RankW-1:0] rank [NumLights];

  // Rank of a light: number of lights with a larger total, or equal and lower id.
  always_comb begin
    for (int k = 0; k < NumLights; k++) begin
      rank[k] = '0;
      for (int j = 0; j < NumLights; j++) begin
        if (j != k) begin
          if ((totals_i[j] > totals_i[k]) || ((totals_i[j] == totals_i[k]) && (j < k))) begin
            rank[k] = rank[k] + RankW'(1);
          end
        end
      end
    end
  end

  // Ranks form a permutation, so OR the one match into each position.
  always_comb begin
    report_o = '0;
    for (int r = 0; r < NumLights; r++) begin
      for (int k = 0; k < NumLights; k++) begin
        if (rank[k] == RankW'(r)) begin
          report_o.light[r] = report_o.light[r] | LightW'(k + 1);
          report_o.total[r] = report_o.total[r] | totals_i[k];
        end
      end
    end
  end

endmodule

[src/pktr_rbuf.sv]
module pktr_rbuf
  import pktr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  report_t report_i,
  output logic    buf_free_o,
  pktr_out_if.source results
);

  light_t [NumLights-1:0] light_q;
  total_t [NumLights-1:0] total_q;
  logic [LeftW-1:0]       left_q;
  logic                   busy, pop;

  assign busy = (left_q != '0);
  assign pop  = busy && results.ready;

  // Free once the final beat of the current report leaves.
  assign buf_free_o = !busy || ((left_q == LeftW'(1)) && results.ready);

  assign results.valid          = busy;
  assign results.ranked_light   = light_q[0];
  assign results.ranked_total   = total_q[0];
  assign results.last_of_report = (left_q == LeftW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (load_i) begin
      left_q <= LeftW'(NumLights);
    end else if (pop) begin
      left_q <= left_q - LeftW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      light_q <= report_i.light;
      total_q <= report_i.total;
    end else if (pop) begin
      for (int i = 0; i < NumLights - 1; i++) begin
        light_q[i] <= light_q[i+1];
        total_q[i] <= total_q[i+1];
      end
    end
  end

endmodule

[src/per_key_tally_ranker.sv]
// Channel   Dir  Payload                                      Beat
// records   in   light_id[8], car_count[16]                   valid & ready
// results   out  ranked_light[3], ranked_total[32], last      valid & ready
// cfg       in   cfg_wdata_i[16] = report_interval            cfg_we_i
//
// A record is taken every cycle while no report record waits on the buffer. It
// passes the input register, then its count is added into its light's total
// and, on a report record, the four totals are ranked by a fixed compare
// network into a report buffer. The buffer sends one result per cycle while
// results are ready, so a report takes four output beats; only a report record
// waits for a busy buffer, other records keep flowing. Reset clears totals, the
// interval counter and all valid state; the interval register comes up at 48.
module per_key_tally_ranker
  import pktr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IvalW-1:0] cfg_wdata_i,
  pktr_in_if.sink          records,
  pktr_out_if.source       results
);

  total_t [NumLights-1:0] totals;
  report_t                report;
  logic                   report_load;
  logic                   buf_free;

  // Input register, interval counter and per-light totals.
  pktr_tally u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (records.valid),
    .in_ready_o    (records.ready),
    .light_id_i    (records.light_id),
    .car_count_i   (records.car_count),
    .buf_free_i    (buf_free),
    .report_load_o (report_load),
    .totals_o      (totals)
  );

  // Rank the freshly updated totals, descending, ties to the lower id.
  pktr_rank u_rank (
    .totals_i (totals),
    .report_o (report)
  );

  // Hold the ranked report and drain it one beat per cycle while results are ready.
  pktr_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (report_load),
    .report_i   (report),
    .buf_free_o (buf_free),
    .results    (results)
  );

endmodule

[tb/tb_per_key_tally_ranker.sv]
`timescale 1ns / 1ps

module tb_per_key_tally_ranker;
  import pktr_pkg::*;

  localparam int unsigned HalfPeriod   = 2;
  localparam int unsigned ResetCycles  = 9;
  // Settle time after the last ranked beat has left, to cover any record still
  // in flight in the input register, rank network and report buffer.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned MaxShown     = 40;

  // Opening records as {light_id, car_count}: bad ids at both ends of the
  // byte, zero and full counts, and two pairs of lights that end up tied.
  localparam logic [23:0] Opening [24] = '{
    24'h00_FFFF, 24'h05_FFFF, 24'hFF_FFFF, 24'h80_0001, 24'h01_0000, 24'h01_FFFF,
    24'h02_FFFF, 24'h03_0001, 24'h04_FFFF, 24'h03_FFFF, 24'h04_0001, 24'h02_AAAA,
    24'h01_5555, 24'h01_5555, 24'h06_5555, 24'hAA_AAAA, 24'h55_5555, 24'h01_0000,
    24'h02_0000, 24'h03_0000, 24'h04_0000, 24'h00_0000, 24'h07_0001, 24'h08_8000
  };

  typedef struct packed {
    light_t light;
    total_t total;
    logic   last;
  } rank_beat_t;

  typedef struct {
    logic [IdW-1:0]    id;
    logic [CountW-1:0] cnt;
    bit                drain_first;  // hold this record until every beat is back
  } record_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [IvalW-1:0] cfg_wdata_i;

  pktr_in_if  rec_if();
  pktr_out_if res_if();

  per_key_tally_ranker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .records     (rec_if),
    .results     (res_if)
  );

  // Predicted block state: per-light totals, interval counter and register.
  total_t           light_sum [NumLights];
  logic [IvalW-1:0] since_report;
  logic [IvalW-1:0] interval_q;

  rank_beat_t report_beats_due[$];
  record_t    records_to_send[$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned sender_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned hold_asks;
  int unsigned holds_served;
  bit          steady;
  bit          rec_taken;
  bit          res_taken;

  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Append at the tail of the pending record list.
  function automatic void enqueue_record(input record_t rec);
    records_to_send.insert(records_to_send.size(), rec);
  endfunction

  // Append at the tail of the expected beat list.
  function automatic void enqueue_beat(input rank_beat_t beat);
    report_beats_due.insert(report_beats_due.size(), beat);
  endfunction

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Add one record into its light, advance the interval count and, when the
  // count hits the interval, queue the four beats of the ranked report.
  function automatic void tally_record(input logic [IdW-1:0] id,
                                       input logic [CountW-1:0] cnt);
    logic [TotalW:0]  sum;
    logic [IvalW-1:0] next_count;
    int unsigned      place;
    rank_beat_t       ranked [NumLights];
    if (id >= 1 && id <= NumLights) begin
      sum = {1'b0, light_sum[int'(id) - 1]} + {{(TotalW + 1 - CountW){1'b0}}, cnt};
      light_sum[int'(id) - 1] = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
    end
    next_count = since_report + IvalW'(1);
    if (next_count != interval_q) begin
      since_report = next_count;
    end else begin
      since_report = '0;
      // A light's place is the number of lights ahead of it: a bigger total,
      // or the same total and a lower id.
      for (int k = 0; k < NumLights; k++) begin
        place = 0;
        for (int j = 0; j < NumLights; j++) begin
          if (j != k && (light_sum[j] > light_sum[k] ||
                         (light_sum[j] == light_sum[k] && j < k))) place++;
        end
        ranked[place] = '{light: light_t'(k + 1), total: light_sum[k],
                          last: (place == NumLights - 1)};
      end
      for (int p = 0; p < NumLights; p++) enqueue_beat(ranked[p]);
    end
  endfunction

  // Heavy records pile full counts onto lights 1 and 2; the rest spread over
  // good ids, bad ids and all count shapes.
  function automatic record_t make_record(input bit heavy);
    record_t     rec;
    int unsigned roll;
    rec.drain_first = 1'b0;
    if (heavy && $urandom_range(0, 9) != 0) begin
      rec.id  = IdW'($urandom_range(1, 2));
      rec.cnt = '1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      rec.id = IdW'($urandom_range(1, NumLights));
      else if (roll < 85) rec.id = '0;
      else                rec.id = IdW'($urandom_range(NumLights + 1, 255));
      roll = $urandom_range(0, 99);
      if (roll < 12)      rec.cnt = '0;
      else if (roll < 24) rec.cnt = '1;
      else if (roll < 50) rec.cnt = CountW'($urandom_range(0, 255));
      else                rec.cnt = CountW'($urandom);
    end
    return rec;
  endfunction

  task automatic send_random(input int unsigned n, input bit heavy);
    for (int unsigned i = 0; i < n; i++) enqueue_record(make_record(heavy));
  endtask

  // Block until all records are taken and all beats are back, then let the
  // pipeline drain so a register write never meets a record in flight.
  task automatic wait_for_quiet();
    while (records_to_send.size() != 0 || rec_if.valid || report_beats_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [IvalW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    interval_q  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Record driver: advance to the next record only after a beat, hold the
  // payload otherwise.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rec_if.valid <= 1'b0;
    end else if (!rec_if.valid || rec_taken) begin
      if (sender_gap > 0) begin
        sender_gap--;
        rec_if.valid <= 1'b0;
      end else if (records_to_send.size() != 0 &&
                   !(records_to_send[0].drain_first && report_beats_due.size() != 0)) begin
        rec_if.valid     <= 1'b1;
        rec_if.light_id  <= records_to_send[0].id;
        rec_if.car_count <= records_to_send[0].cnt;
        void'(records_to_send.pop_front());
        sender_gap = pick_gap();
      end else begin
        rec_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off whenever one is asked.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (holds_served != hold_asks) begin
      holds_served++;
      hold_left = HoldCycles - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      res_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Monitor: feed taken records to the predictor, check every result beat
  // against the oldest one due, and watch for a stalled run.
  always @(posedge clk_i) begin
    rec_taken = rec_if.valid && rec_if.ready;
    res_taken = res_if.valid && res_if.ready;
    if (rst_ni) begin
      if (rec_taken) tally_record(rec_if.light_id, rec_if.car_count);
      if (res_taken) begin
        if (report_beats_due.size() == 0) begin
          if (mismatches < MaxShown)
            $display("%0t: unexpected beat, expected none, got light %0d total %0h last %0b",
                     $time, res_if.ranked_light, res_if.ranked_total, res_if.last_of_report);
          mismatches++;
        end else begin
          if (res_if.ranked_light !== report_beats_due[0].light) begin
            if (mismatches < MaxShown)
              $display("%0t: ranked_light expected %0d, got %0d", $time,
                       report_beats_due[0].light, res_if.ranked_light);
            mismatches++;
          end
          if (res_if.ranked_total !== report_beats_due[0].total) begin
            if (mismatches < MaxShown)
              $display("%0t: ranked_total expected %0h, got %0h", $time,
                       report_beats_due[0].total, res_if.ranked_total);
            mismatches++;
          end
          if (res_if.last_of_report !== report_beats_due[0].last) begin
            if (mismatches < MaxShown)
              $display("%0t: last_of_report expected %0b, got %0b", $time,
                       report_beats_due[0].last, res_if.last_of_report);
            mismatches++;
          end
          void'(report_beats_due.pop_front());
        end
      end
      quiet_cycles = (rec_taken || res_taken) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("per_key_tally_ranker regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ival;
    int unsigned n;
    record_t     rec;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    rec_if.valid     = 1'b0;
    rec_if.light_id  = '0;
    rec_if.car_count = '0;
    res_if.ready     = 1'b0;
    for (int k = 0; k < NumLights; k++) light_sum[k] = '0;
    since_report = '0;
    interval_q   = IvalReset;
    mismatches   = 0;
    quiet_cycles = 0;
    sender_gap   = 0;
    stall_left   = 0;
    hold_left    = 0;
    hold_asks    = 0;
    holds_served = 0;
    steady       = 1'b0;
    rec_taken    = 1'b0;
    res_taken    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Interval at its reset value of 48: opening records, then bad ids only,
    // which still count toward the interval and keep both ties intact.
    foreach (Opening[i]) begin
      rec.id          = Opening[i][23:16];
      rec.cnt         = Opening[i][15:0];
      rec.drain_first = 1'b0;
      enqueue_record(rec);
    end
    for (int i = 0; i < 24; i++) begin
      rec.id          = $urandom_range(0, 1) ? '0 : IdW'($urandom_range(NumLights + 1, 255));
      rec.cnt         = CountW'($urandom);
      rec.drain_first = 1'b0;
      enqueue_record(rec);
    end
    wait_for_quiet();

    // Report on every record; pause the sender once until all beats are back.
    write_interval(IvalW'(1));
    send_random(20, 1'b0);
    rec = make_record(1'b0);
    rec.drain_first = 1'b1;
    enqueue_record(rec);
    send_random(20, 1'b0);
    wait_for_quiet();

    // Long receiver hold-off with the sender flat out: the report buffer
    // fills and the record input has to stall.
    steady = 1'b1;
    hold_asks++;
    send_random(40, 1'b0);
    wait_for_quiet();
    steady = 1'b0;

    write_interval(IvalW'($urandom_range(2, 9)));
    for (int i = 0; i < 3; i++) begin
      send_random(40, 1'b0);
      rec = make_record(1'b0);
      rec.drain_first = 1'b1;
      enqueue_record(rec);
    end
    wait_for_quiet();

    // Mid-size interval; stop five records past a report.
    ival = $urandom_range(10, 20);
    write_interval(IvalW'(ival));
    n = (ival - since_report) + 2 * ival + 5;
    send_random(n, 1'b0);
    wait_for_quiet();

    // Short interval above the count, with full-count records on lights 1
    // and 2 so their totals climb and meet.
    write_interval(IvalW'($urandom_range(6, 9)));
    send_random(60, 1'b1);
    wait_for_quiet();

    if (mismatches == 0) begin
      $display("per_key_tally_ranker regression: pass");
    end else begin
      $display("per_key_tally_ranker regression: fail");
    end
    $finish;
  end

endmodule
